// ===== hw/rtl/csa_pkg.sv =====
// ----------------------------------------------------------------------------
// csa_pkg: shared types and constants for the cosine similarity accumulator
// Fixed-point widths, transfer payload structs, back-end state encoding and
// the saturating accumulate helper.
// ----------------------------------------------------------------------------
package csa_pkg;

    // Input sample width (Q5.10) and accumulator width (Q27.20)
    localparam int VALUE_BITS  = 16;
    localparam int ACC_W       = 48;
    localparam int PROD_W      = 2 * VALUE_BITS;
    localparam int HALF_W      = ACC_W / 2;
    localparam int WIDE_W      = 2 * ACC_W;

    // Quotient search: 15 result bits cover 0..16384 (Q1.14)
    localparam int Q_BITS      = 15;
    localparam int K_W         = 4;
    localparam int K_TOP       = Q_BITS - 1;
    localparam int FRAC_SHIFT  = 2 * (Q_BITS - 1);
    localparam int SQ_W        = WIDE_W + 2 * Q_BITS;
    localparam int SH_W        = 5;

    // Partial-product sequencer: two 48x48 products, four 24x24 pieces each
    localparam int MUL_STEPS   = 8;
    localparam int MCNT_W      = 4;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [15:0] value_a;
        logic signed [15:0] value_b;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] cosine;
        logic               zero_norm;
    } t_out_item;

    // Finished sums of one vector pair
    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic        [ACC_W-1:0] norm_a;
        logic        [ACC_W-1:0] norm_b;
    } t_sums;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_STEP,
        BK_TEST,
        BK_DONE
    } t_back_state;

    // Saturating add of a product into an accumulator
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [ACC_W:0] s;
        s = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){prod[PROD_W-1]}}, prod};
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/csa_front.sv =====
// ----------------------------------------------------------------------------
// csa_front: product stage and saturating accumulators
// Takes one row per cycle unless a last row waits on a full queue; forms
// a*b, a*a and b*b in a register stage, then adds them into the three sums.
// A last row hands the final sums to the queue and clears the accumulators.
// ----------------------------------------------------------------------------
module csa_front import csa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    output logic     o_push,
    output t_sums    o_push_data,
    input  logic     i_full
);

    logic                     r_s1_valid;
    logic                     r_s1_last;
    logic signed [PROD_W-1:0] r_s1_ab;
    logic signed [PROD_W-1:0] r_s1_aa;
    logic signed [PROD_W-1:0] r_s1_bb;
    logic signed [ACC_W-1:0]  r_dot;
    logic signed [ACC_W-1:0]  r_na;
    logic signed [ACC_W-1:0]  r_nb;
    logic signed [ACC_W-1:0]  n_dot;
    logic signed [ACC_W-1:0]  n_na;
    logic signed [ACC_W-1:0]  n_nb;

    logic signed [VALUE_BITS-1:0] a_val;
    logic signed [VALUE_BITS-1:0] b_val;
    logic                         s1_go;
    logic                         in_take;

    // Stage 1 drains unless it holds a last row and the queue is full
    assign s1_go      = r_s1_valid && (!r_s1_last || !i_full);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_take    = i_in_valid && o_in_ready;

    assign a_val = i_in_data.value_a[VALUE_BITS-1:0];
    assign b_val = i_in_data.value_b[VALUE_BITS-1:0];

    // Accumulate with saturation
    always_comb begin
        n_dot = sat_add(r_dot, r_s1_ab);
        n_na  = sat_add(r_na, r_s1_aa);
        n_nb  = sat_add(r_nb, r_s1_bb);
    end

    assign o_push             = s1_go && r_s1_last;
    assign o_push_data.dot    = n_dot;
    assign o_push_data.norm_a = n_na;
    assign o_push_data.norm_b = n_nb;

    // Products, registered
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_ab   <= a_val * b_val;
            r_s1_aa   <= a_val * a_val;
            r_s1_bb   <= b_val * b_val;
            r_s1_last <= i_in_data.last;
        end
    end

    // Stage valid and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_dot      <= '0;
            r_na       <= '0;
            r_nb       <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_go) begin
                if (r_s1_last) begin
                    r_dot <= '0;
                    r_na  <= '0;
                    r_nb  <= '0;
                end else begin
                    r_dot <= n_dot;
                    r_na  <= n_na;
                    r_nb  <= n_nb;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/csa_queue.sv =====
// ----------------------------------------------------------------------------
// csa_queue: two-entry queue of finished sums
// Lets the accumulators start the next vector pair while the back end is
// still working on the previous one.
// ----------------------------------------------------------------------------
module csa_queue import csa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_sums i_push_data,
    input  logic  i_pop,
    output t_sums o_head,
    output logic  o_full,
    output logic  o_empty
);

    t_sums             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/csa_back.sv =====
// ----------------------------------------------------------------------------
// csa_back: cosine quotient unit
// Forms P = norm_a*norm_b and D = dot^2 with one shared 24x24 multiplier over
// eight pieces, then finds the largest q <= 16384 with q^2*P <= D*2^28 bit by
// bit, keeping q^2*P and q*P updated by shifts and adds.
// ----------------------------------------------------------------------------
module csa_back import csa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_sums     i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_back_state r_state;
    t_back_state n_state;

    logic                r_neg;
    logic                r_zero;
    logic [ACC_W-1:0]    r_na;
    logic [ACC_W-1:0]    r_nb;
    logic [ACC_W-1:0]    r_dmag;
    logic [WIDE_W-1:0]   r_p;
    logic [WIDE_W-1:0]   r_d;
    logic [MCNT_W-1:0]   r_mcnt;
    logic [ACC_W-1:0]    r_pp;
    logic                r_pp_valid;
    logic                r_pp_sel;
    logic [1:0]          r_pp_sh;
    logic [K_W-1:0]      r_k;
    logic [Q_BITS-1:0]   r_q;
    logic [SQ_W-1:0]     r_s;
    logic [SQ_W-1:0]     r_qp;
    logic [SQ_W-1:0]     r_inc;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                zero_head;
    logic [ACC_W-1:0]    head_dmag;
    logic [2:0]          mj;
    logic [ACC_W-1:0]    mx;
    logic [ACC_W-1:0]    my;
    logic [HALF_W-1:0]   mx_h;
    logic [HALF_W-1:0]   my_h;
    logic [WIDE_W-1:0]   pp_shifted;
    logic                mul_issue;
    logic [SQ_W-1:0]     p_ext;
    logic [SQ_W-1:0]     d_lim;
    logic [SQ_W-1:0]     trial;
    logic                pass;
    logic [SH_W-1:0]     sh_qp;
    logic [SH_W-1:0]     sh_p;
    logic                search_end;
    logic                out_load;
    logic [15:0]         q_ext;

    assign o_pop       = (r_state == BK_IDLE) && !i_empty;
    assign zero_head   = (i_head.norm_a == '0) || (i_head.norm_b == '0);
    assign head_dmag   = i_head.dot[ACC_W-1] ? (ACC_W'(0) - i_head.dot) : i_head.dot;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Partial-product operand select: j[2] picks the product, j[1:0] the halves
    assign mj        = r_mcnt[2:0];
    assign mul_issue = (r_state == BK_MUL) && (r_mcnt < MCNT_W'(MUL_STEPS));
    assign mx        = mj[2] ? r_dmag : r_na;
    assign my        = mj[2] ? r_dmag : r_nb;
    assign mx_h      = mj[0] ? mx[ACC_W-1:HALF_W] : mx[HALF_W-1:0];
    assign my_h      = mj[1] ? my[ACC_W-1:HALF_W] : my[HALF_W-1:0];

    // Align the registered piece by its half positions
    always_comb begin
        unique case (r_pp_sh)
            2'd0:    pp_shifted = WIDE_W'(r_pp);
            2'd1:    pp_shifted = WIDE_W'(r_pp) << HALF_W;
            2'd2:    pp_shifted = WIDE_W'(r_pp) << ACC_W;
            default: pp_shifted = '0;
        endcase
    end

    // Bit trial of the quotient search
    assign p_ext      = SQ_W'(r_p);
    assign d_lim      = SQ_W'({r_d, {FRAC_SHIFT{1'b0}}});
    assign trial      = r_s + r_inc;
    assign pass       = (trial <= d_lim);
    assign sh_qp      = SH_W'(r_k) + SH_W'(1);
    assign sh_p       = SH_W'(r_k) << 1;
    assign search_end = (pass && (r_k == K_W'(K_TOP))) || (r_k == '0);
    assign out_load   = (r_state == BK_DONE) && (!r_out_valid || i_out_ready);
    assign q_ext      = {1'b0, r_q};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    n_state = zero_head ? BK_DONE : BK_MUL;
                end
            end
            BK_MUL: begin
                if (r_mcnt == MCNT_W'(MUL_STEPS)) begin
                    n_state = BK_STEP;
                end
            end
            BK_STEP: begin
                n_state = BK_TEST;
            end
            BK_TEST: begin
                n_state = search_end ? BK_DONE : BK_STEP;
            end
            BK_DONE: begin
                if (out_load) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.zero_norm <= r_zero;
            if (r_zero) begin
                r_out.cosine <= '0;
            end else begin
                r_out.cosine <= r_neg ? (16'd0 - q_ext) : q_ext;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    r_na       <= i_head.norm_a;
                    r_nb       <= i_head.norm_b;
                    r_dmag     <= head_dmag;
                    r_neg      <= i_head.dot[ACC_W-1];
                    r_zero     <= zero_head;
                    r_p        <= '0;
                    r_d        <= '0;
                    r_mcnt     <= '0;
                    r_pp_valid <= 1'b0;
                    r_k        <= K_W'(K_TOP);
                    r_q        <= '0;
                    r_s        <= '0;
                    r_qp       <= '0;
                end
            end
            BK_MUL: begin
                r_mcnt     <= r_mcnt + 1'b1;
                r_pp_valid <= mul_issue;
                r_pp       <= mx_h * my_h;
                r_pp_sel   <= mj[2];
                r_pp_sh    <= {1'b0, mj[0]} + {1'b0, mj[1]};
                if (r_pp_valid) begin
                    if (r_pp_sel) begin
                        r_d <= r_d + pp_shifted;
                    end else begin
                        r_p <= r_p + pp_shifted;
                    end
                end
            end
            BK_STEP: begin
                r_inc <= (r_qp << sh_qp) + (p_ext << sh_p);
            end
            BK_TEST: begin
                if (pass) begin
                    r_s      <= trial;
                    r_qp     <= r_qp + (p_ext << r_k);
                    r_q[r_k] <= 1'b1;
                end
                r_k <= r_k - 1'b1;
            end
            BK_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/cosine_similarity_accumulate.sv =====
// Throughput: one row per cycle into the accumulators; the quotient unit takes one
// pair at a time; a last row that meets two finished pairs in the queue stalls input.
// Result path: product register, queue, back end; on a zero norm the back end goes
// straight to the output register, else via the 24x24 multiplier and quotient search.
// Reset (synchronous, active low) clears the sums, the queue and the output valid flag.
// ----------------------------------------------------------------------------
// cosine_similarity_accumulate: streaming cosine similarity of two columns
// Front end accumulates dot product and squared norms; back end turns each
// finished triple into a saturated Q1.14 cosine.
// ----------------------------------------------------------------------------
module cosine_similarity_accumulate import csa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_sums push_data;
    t_sums head;

    csa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    csa_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_full      (full),
        .o_empty     (empty)
    );

    csa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sim/cosine_similarity_accumulate_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cosine_similarity_accumulate_tb: self-checking bench for the cosine unit
// Streams rating vector pairs into the block, predicts each Q1.14 similarity
// with a bit-exact integer model, and compares every output transfer in order.
// ----------------------------------------------------------------------------
module cosine_similarity_accumulate_tb import csa_pkg::*;;

    localparam int CLK_HALF    = 6;
    localparam int RANDOM_ROWS = 1840;
    localparam int DRAIN_WAIT  = 80;
    localparam int LONG_ROWS   = 40;

    // Shapes of random vector pairs
    typedef enum int {
        MIX_RANDOM,
        MIX_SAME,
        MIX_NEG,
        MIX_NEAR,
        MIX_TINY,
        MIX_ZERO_A,
        MIX_CORNER
    } t_mix;

    // Receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PULSE
    } t_rx_mode;

    // One directed row, repeated reps times; last is applied to the final copy
    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        bit                 last;
        int                 reps;
        bit                 typed;
        t_out_item          want;
    } t_dir_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    // Predictor state: running sums of the current vector pair
    logic signed [47:0] dot_acc;
    logic signed [47:0] norm_a_acc;
    logic signed [47:0] norm_b_acc;

    t_out_item cosine_q[$];
    int        error_count;
    int        rows_sent;
    int        results_seen;
    int        zero_results;
    int        burst_left;
    int        rx_cycle;
    t_rx_mode  rx_mode;

    cosine_similarity_accumulate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Saturating 48-bit accumulate of a 32-bit product
    function automatic logic signed [47:0] sum_sat(input logic signed [47:0] acc,
                                                   input logic signed [31:0] prod);
        logic signed [48:0] s;
        s = acc + prod;
        if (s > ACC_MAX) begin
            sum_sat = ACC_MAX;
        end else if (s < ACC_MIN) begin
            sum_sat = ACC_MIN;
        end else begin
            sum_sat = s[47:0];
        end
    endfunction

    // Largest q in 0..16384 with q*q*na*nb <= dmag*dmag*2^28
    function automatic logic [14:0] cosine_magnitude(input logic [47:0] dmag,
                                                     input logic [47:0] na,
                                                     input logic [47:0] nb);
        logic [127:0] bound;
        logic [127:0] lhs;
        logic [127:0] dm;
        logic [127:0] q_sq;
        int lo;
        int hi;
        int mid;
        dm    = dmag;
        bound = (dm * dm) << 28;
        lo    = 0;
        hi    = 16384;
        while (lo < hi) begin
            mid  = (lo + hi + 1) / 2;
            q_sq = mid * mid;
            lhs  = q_sq * na * nb;
            if (lhs <= bound) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        cosine_magnitude = lo[14:0];
    endfunction

    // Fold one row into the sums; on last, produce the similarity and clear
    task automatic predict_row(input t_in_item row, output bit has_res,
                               output t_out_item res);
        logic signed [31:0] p_ab;
        logic signed [31:0] p_aa;
        logic signed [31:0] p_bb;
        logic        [47:0] dmag;
        logic        [14:0] mag;
        p_ab       = row.value_a * row.value_b;
        p_aa       = row.value_a * row.value_a;
        p_bb       = row.value_b * row.value_b;
        dot_acc    = sum_sat(dot_acc, p_ab);
        norm_a_acc = sum_sat(norm_a_acc, p_aa);
        norm_b_acc = sum_sat(norm_b_acc, p_bb);
        has_res    = row.last;
        res        = '0;
        if (row.last) begin
            if (norm_a_acc == 0 || norm_b_acc == 0) begin
                res.cosine    = '0;
                res.zero_norm = 1'b1;
            end else begin
                dmag = dot_acc[47] ? 48'(-dot_acc) : 48'(dot_acc);
                mag  = cosine_magnitude(dmag, norm_a_acc, norm_b_acc);
                res.cosine    = dot_acc[47] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                res.zero_norm = 1'b0;
            end
            dot_acc    = '0;
            norm_a_acc = '0;
            norm_b_acc = '0;
        end
    endtask

    // Send one row with bursty pacing; queue its result at the accepting edge
    task automatic send_row(input t_in_item row, input bit typed, input t_out_item want);
        int        gap;
        bit        has_res;
        t_out_item pred;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= row;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        rows_sent++;
        predict_row(row, has_res, pred);
        if (has_res) begin
            cosine_q.insert(cosine_q.size(), typed ? want : pred);
        end
    endtask

    // Receiver ready under a stall pattern that is switched at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_cycle    <= 0;
            rx_mode     <= RX_OPEN;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 100 == 99) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
            end
            case (rx_mode)
                RX_OPEN:   i_out_ready <= 1'b1;
                RX_COIN:   i_out_ready <= $urandom_range(0, 1);
                RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                RX_PULSE:  i_out_ready <= (rx_cycle % 24 >= 18);
                default:   i_out_ready <= 1'b1;
            endcase
        end
    end

    // Result checker: each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (o_out_data.zero_norm) begin
                zero_results++;
            end
            if (cosine_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result cosine=%0d zero_norm=%0b",
                                          o_out_data.cosine, o_out_data.zero_norm));
            end else begin
                want = cosine_q.pop_front();
                if (o_out_data.cosine !== want.cosine) begin
                    report_mismatch($sformatf("result %0d: cosine got %0d expected %0d",
                                              results_seen, o_out_data.cosine, want.cosine));
                end
                if (o_out_data.zero_norm !== want.zero_norm) begin
                    report_mismatch($sformatf("result %0d: zero_norm got %0b expected %0b",
                                              results_seen, o_out_data.zero_norm,
                                              want.zero_norm));
                end
            end
        end
    end

    // Main sequence: reset, directed table, random vector pairs, drain
    initial begin
        t_dir_row           dir_rows [25];
        logic signed [15:0] corner_vals [5];
        t_in_item           row;
        t_out_item          no_want;
        t_mix               mix;
        int                 rand_rows;
        int                 len;

        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        dot_acc     = '0;
        norm_a_acc  = '0;
        norm_b_acc  = '0;
        error_count = 0;
        rows_sent   = 0;
        results_seen = 0;
        zero_results = 0;
        burst_left  = 0;
        rand_rows   = 0;
        no_want     = '0;
        corner_vals = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1};

        dir_rows = '{
            // zero norms: both, b only, a only
            '{16'sd0,      16'sd0,      1'b1, 1, 1'b1, '{16'sd0, 1'b1}},
            '{16'sd5,      16'sd0,      1'b1, 1, 1'b1, '{16'sd0, 1'b1}},
            '{16'sd0,      -16'sd7,     1'b1, 1, 1'b1, '{16'sd0, 1'b1}},
            // parallel and antiparallel single rows
            '{16'sd1024,   16'sd1024,   1'b1, 1, 1'b1, '{16'sd16384, 1'b0}},
            '{16'sd1024,   -16'sd1024,  1'b1, 1, 1'b1, '{-16'sd16384, 1'b0}},
            '{-16'sd32768, -16'sd32768, 1'b1, 1, 1'b1, '{16'sd16384, 1'b0}},
            '{16'sd32767,  -16'sd32768, 1'b1, 1, 1'b1, '{-16'sd16384, 1'b0}},
            '{16'sd32767,  16'sd32767,  1'b1, 1, 1'b1, '{16'sd16384, 1'b0}},
            '{-16'sd1,     16'sd1,      1'b1, 1, 1'b1, '{-16'sd16384, 1'b0}},
            // orthogonal pair spread over two rows
            '{16'sd1024,   16'sd0,      1'b0, 1, 1'b0, '{16'sd0, 1'b0}},
            '{16'sd0,      16'sd1024,   1'b1, 1, 1'b1, '{16'sd0, 1'b0}},
            // short mixed vectors
            '{16'sd3,      -16'sd5,     1'b0, 1, 1'b0, '{16'sd0, 1'b0}},
            '{16'sd100,    16'sd200,    1'b0, 1, 1'b0, '{16'sd0, 1'b0}},
            '{-16'sd7,     16'sd9,      1'b1, 1, 1'b0, '{16'sd0, 1'b0}},
            '{16'sd1,      16'sd1,      1'b0, 1, 1'b0, '{16'sd0, 1'b0}},
            '{16'sd1,      16'sd0,      1'b1, 1, 1'b0, '{16'sd0, 1'b0}},
            '{-16'sd1,     -16'sd1,     1'b0, 3, 1'b0, '{16'sd0, 1'b0}},
            '{16'sd2,      -16'sd3,     1'b1, 1, 1'b0, '{16'sd0, 1'b0}},
            '{16'sd12345,  -16'sd23456, 1'b0, 4, 1'b0, '{16'sd0, 1'b0}},
            '{-16'sd32768, 16'sd32767,  1'b1, 1, 1'b0, '{16'sd0, 1'b0}},
            // long full-scale antiparallel pair, exactly minus one
            '{-16'sd32768, 16'sd32767,  1'b1, LONG_ROWS, 1'b1, '{-16'sd16384, 1'b0}},
            // long pair with tiny b, exactly plus one
            '{-16'sd32768, -16'sd1,     1'b1, LONG_ROWS, 1'b1, '{16'sd16384, 1'b0}},
            // sums must be clear again after the long pairs
            '{16'sd0,      16'sd0,      1'b1, 1, 1'b1, '{16'sd0, 1'b1}},
            '{16'sd0,      16'sd9,      1'b0, 1, 1'b0, '{16'sd0, 1'b0}},
            '{16'sd11,     16'sd0,      1'b1, 1, 1'b0, '{16'sd0, 1'b0}}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].reps; k++) begin
                row.value_a = dir_rows[r].a;
                row.value_b = dir_rows[r].b;
                row.last    = dir_rows[r].last && (k == dir_rows[r].reps - 1);
                send_row(row, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        // Random vector pairs of mostly short length
        while (rand_rows < RANDOM_ROWS) begin
            mix = t_mix'($urandom_range(0, 6));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                row.value_a = 16'($urandom);
                row.value_b = 16'($urandom);
                case (mix)
                    MIX_SAME:   row.value_b = row.value_a;
                    MIX_NEG:    row.value_b = -row.value_a;
                    MIX_NEAR:   row.value_b = row.value_a + 16'($urandom_range(0, 64)) - 16'sd32;
                    MIX_TINY: begin
                        row.value_a = 16'(int'($urandom_range(0, 8)) - 4);
                        row.value_b = 16'(int'($urandom_range(0, 8)) - 4);
                    end
                    MIX_ZERO_A: row.value_a = '0;
                    MIX_CORNER: begin
                        row.value_a = corner_vals[$urandom_range(0, 4)];
                        row.value_b = corner_vals[$urandom_range(0, 4)];
                    end
                    default: ;
                endcase
                row.last = (i == len - 1);
                send_row(row, 1'b0, no_want);
                rand_rows++;
            end
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (cosine_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d rows (directed, long and random pairs); checked %0d results,",
                 rows_sent, results_seen);
        $display("%0d of them zero-norm, with %0d mismatches.", zero_results, error_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(100_000_000);
        $display("ERROR: timeout with %0d results outstanding", cosine_q.size());
        $display("FAIL");
        $finish;
    end

endmodule
